### hw/rtl/bcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

	localparam int DIV_N_W    = 32;
	localparam int DIV_D_W    = 11;
	localparam int DIV_STEP_W = $clog2(DIV_N_W);

	localparam int REF_W  = 4;
	localparam int CNT_W  = 32;
	localparam int LEN_W  = 16;
	localparam int CIDX_W = 2;
	localparam int CDAT_W = 11;

	localparam logic [CIDX_W-1:0] CFG_BIN_SIZE   = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_MIN_MAPQ   = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_UNIQUE     = 2'd2;

	localparam logic [10:0] BIN_SIZE_RESET = 11'd10;
	localparam logic [7:0]  MIN_MAPQ_RESET = 8'd10;
	localparam int          SECONDARY_BIT  = 8;

	typedef struct packed {
		logic               start;
		logic [DIV_N_W-1:0] dividend;
		logic [DIV_D_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DIV_N_W-1:0] quotient;
		logic [DIV_D_W-1:0] remainder;
	} div_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/binned_coverage_counter.sv
`timescale 1ns / 1ps
`default_nettype none

// channel | direction | handshake            | payload
// cfg     | in        | cfg_we               | cfg_index, cfg_data
// in      | in        | in_valid / in_ready  | cmd .. bin_index
// out     | out       | out_valid / out_ready| counted, out_of_range, raw_count, mean_depth
//
// after reset a clearing pass writes zero to all NUM_REFS*BINS_PER_REF bins, one a cycle;
// in_ready stays low meanwhile, config writes are taken.
// count beat: runs through the shared 32-step divider, then reads and writes the bin memory
// for each bin touched; dropped, empty or unaddressable records skip the divider and the bin memory.
// readout beat: reads the bin memory, then divides the count by the bin size in the same divider.
// a finished result sits in the output register while the next beat is accepted;
// the one after that waits in S_DONE until out_ready frees the register.
module binned_coverage_counter #(
	parameter int NUM_REFS     = 16,
	parameter int BINS_PER_REF = 4096
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [bcc_pkg::CIDX_W-1:0]  cfg_index,
	input  wire logic [bcc_pkg::CDAT_W-1:0]  cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        cmd,
	input  wire logic [bcc_pkg::REF_W-1:0]   ref_index,
	input  wire logic [31:0]                 start_pos,
	input  wire logic [bcc_pkg::LEN_W-1:0]   aligned_length,
	input  wire logic [11:0]                 flags,
	input  wire logic [7:0]                  map_quality,
	input  wire logic [31:0]                 read_id,
	input  wire logic [31:0]                 subread_group,
	input  wire logic                        group_valid,
	input  wire logic [11:0]                 bin_index,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             counted,
	output logic                             out_of_range,
	output logic [bcc_pkg::CNT_W-1:0]        raw_count,
	output logic [bcc_pkg::CNT_W-1:0]        mean_depth
);

	localparam int DEPTH  = NUM_REFS * BINS_PER_REF;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int BIN_W  = $clog2(BINS_PER_REF);
	localparam int PROD_W = ADDR_W + bcc_pkg::REF_W;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_EVAL, S_CNT_START, S_CNT_DIV, S_BIN_RD, S_BIN_WR,
		S_RO_RD, S_RO_DATA, S_RO_DIV, S_DONE
	} state_t;

	state_t state_q;

	logic [10:0] bin_size_q;
	logic [7:0]  min_mapq_q;
	logic        unique_q;

	logic                         cmd_q;
	logic [bcc_pkg::REF_W-1:0]    ref_q;
	logic [31:0]                  start_q;
	logic [bcc_pkg::LEN_W-1:0]    len_q;
	logic [11:0]                  flags_q;
	logic [7:0]                   mapq_q;
	logic [31:0]                  rid_q;
	logic [31:0]                  grp_q;
	logic                         gval_q;
	logic [11:0]                  bidx_q;

	logic        prev_known_q;
	logic [31:0] prev_rid_q;
	logic [31:0] prev_grp_q;
	logic        prev_gval_q;

	logic [ADDR_W-1:0]          clr_addr_q;
	logic [ADDR_W-1:0]          base_q;
	logic [31:0]                bin_q;
	logic [31:0]                lo_q;
	logic [bcc_pkg::LEN_W-1:0]  rem_q;
	logic [10:0]                avail_q;
	logic [bcc_pkg::CNT_W-1:0]  rdata_q;

	logic                       res_counted_q;
	logic                       res_oor_q;
	logic [bcc_pkg::CNT_W-1:0]  res_raw_q;
	logic [bcc_pkg::CNT_W-1:0]  res_mean_q;

	logic                       out_valid_q;
	logic                       counted_q;
	logic                       oor_q;
	logic [bcc_pkg::CNT_W-1:0]  raw_q;
	logic [bcc_pkg::CNT_W-1:0]  mean_q;

	logic [bcc_pkg::CNT_W-1:0] mem_q [DEPTH];

	logic [10:0]               bs_eff;
	logic                      ref_oor;
	logic                      bidx_oor;
	logic                      bin_oor;
	logic                      dropped;
	logic                      same_read;
	logic                      same_group;
	logic                      take;
	logic [ADDR_W-1:0]         base_c;
	logic [ADDR_W-1:0]         addr;
	logic [bcc_pkg::LEN_W-1:0] step_cnt;
	logic                      rd_en;
	logic                      wr_en;
	logic [ADDR_W-1:0]         wr_addr;
	logic [bcc_pkg::CNT_W-1:0] wr_data;

	bcc_pkg::div_req_t div_req;
	bcc_pkg::div_rsp_t div_rsp;

	always_comb begin
		bs_eff     = (bin_size_q == 11'd0) ? 11'd1 : bin_size_q;
		ref_oor    = (32'(ref_q) >= 32'(NUM_REFS));
		bidx_oor   = (32'(bidx_q) >= 32'(BINS_PER_REF));
		bin_oor    = (bin_q >= 32'(BINS_PER_REF));
		dropped    = flags_q[bcc_pkg::SECONDARY_BIT] || (mapq_q < min_mapq_q);
		same_read  = prev_known_q && (rid_q == prev_rid_q);
		same_group = prev_known_q && gval_q && prev_gval_q && (grp_q == prev_grp_q);
		take       = !unique_q || same_read || !same_group;
		base_c     = ADDR_W'(PROD_W'(ref_q) * PROD_W'(BINS_PER_REF));
		addr       = base_q + ADDR_W'(bin_q[BIN_W-1:0]);
		step_cnt   = (rem_q < bcc_pkg::LEN_W'(avail_q)) ? rem_q : bcc_pkg::LEN_W'(avail_q);
		rd_en      = (state_q == S_RO_RD) ||
		             ((state_q == S_BIN_RD) && (rem_q != '0) && !bin_oor);
		wr_en      = (state_q == S_CLEAR) || (state_q == S_BIN_WR);
		wr_addr    = (state_q == S_CLEAR) ? clr_addr_q : addr;
		wr_data    = (state_q == S_CLEAR) ? '0 :
		             rdata_q + bcc_pkg::CNT_W'(step_cnt);
	end

	always_comb begin
		div_req.start    = (state_q == S_CNT_START) || (state_q == S_RO_DATA);
		div_req.dividend = (state_q == S_RO_DATA) ? rdata_q : lo_q;
		div_req.divisor  = bs_eff;
	end

	bcc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem_q[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_size_q <= bcc_pkg::BIN_SIZE_RESET;
			min_mapq_q <= bcc_pkg::MIN_MAPQ_RESET;
			unique_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				bcc_pkg::CFG_BIN_SIZE: bin_size_q <= cfg_data;
				bcc_pkg::CFG_MIN_MAPQ: min_mapq_q <= cfg_data[7:0];
				bcc_pkg::CFG_UNIQUE:   unique_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q   <= cmd;
			ref_q   <= ref_index;
			start_q <= start_pos;
			len_q   <= aligned_length;
			flags_q <= flags;
			mapq_q  <= map_quality;
			rid_q   <= read_id;
			grp_q   <= subread_group;
			gval_q  <= group_valid;
			bidx_q  <= bin_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_addr_q   <= '0;
			prev_known_q <= 1'b0;
			prev_rid_q   <= '0;
			prev_grp_q   <= '0;
			prev_gval_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					res_raw_q     <= '0;
					res_mean_q    <= '0;
					base_q        <= base_c;
					bin_q         <= 32'(bidx_q);
					if (cmd_q) begin
						res_counted_q <= 1'b0;
						res_oor_q     <= ref_oor || bidx_oor;
						if (ref_oor || bidx_oor) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_RO_RD;
						end
					end else if (dropped) begin
						res_counted_q <= 1'b0;
						res_oor_q     <= 1'b0;
						state_q       <= S_DONE;
					end else begin
						prev_known_q <= 1'b1;
						prev_rid_q   <= rid_q;
						prev_grp_q   <= grp_q;
						prev_gval_q  <= gval_q;
						res_counted_q <= take;
						if (!take || len_q == '0) begin
							res_oor_q <= 1'b0;
							state_q   <= S_DONE;
						end else if (ref_oor) begin
							res_oor_q <= 1'b1;
							state_q   <= S_DONE;
						end else begin
							// position zero lies before the table
							if (start_q == '0) begin
								lo_q      <= '0;
								rem_q     <= len_q - 1'b1;
								res_oor_q <= 1'b1;
							end else begin
								lo_q      <= start_q - 1'b1;
								rem_q     <= len_q;
								res_oor_q <= 1'b0;
							end
							state_q <= S_CNT_START;
						end
					end
				end
				S_CNT_START: begin
					state_q <= S_CNT_DIV;
				end
				S_CNT_DIV: begin
					if (div_rsp.done) begin
						bin_q   <= div_rsp.quotient;
						avail_q <= bs_eff - div_rsp.remainder;
						state_q <= S_BIN_RD;
					end
				end
				S_BIN_RD: begin
					if (rem_q == '0) begin
						state_q <= S_DONE;
					end else if (bin_oor) begin
						// span runs past the last bin of the reference
						res_oor_q <= 1'b1;
						state_q   <= S_DONE;
					end else begin
						state_q <= S_BIN_WR;
					end
				end
				S_BIN_WR: begin
					rem_q   <= rem_q - step_cnt;
					avail_q <= bs_eff;
					bin_q   <= bin_q + 1'b1;
					state_q <= S_BIN_RD;
				end
				S_RO_RD: begin
					state_q <= S_RO_DATA;
				end
				S_RO_DATA: begin
					res_raw_q <= rdata_q;
					state_q   <= S_RO_DIV;
				end
				S_RO_DIV: begin
					if (div_rsp.done) begin
						res_mean_q <= div_rsp.quotient;
						state_q    <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						counted_q   <= res_counted_q;
						oor_q       <= res_oor_q;
						raw_q       <= res_raw_q;
						mean_q      <= res_mean_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign counted      = counted_q;
	assign out_of_range = oor_q;
	assign raw_count    = raw_q;
	assign mean_depth   = mean_q;

endmodule

`default_nettype wire

### hw/rtl/bcc_div.sv
`timescale 1ns / 1ps
`default_nettype none

module bcc_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bcc_pkg::div_req_t req,
	output bcc_pkg::div_rsp_t      rsp
);

	logic                           busy_q;
	logic                           done_q;
	logic [bcc_pkg::DIV_STEP_W-1:0] step_q;
	logic [bcc_pkg::DIV_N_W-1:0]    dvd_q;
	logic [bcc_pkg::DIV_D_W-1:0]    dvs_q;
	logic [bcc_pkg::DIV_D_W-1:0]    rem_q;

	logic [bcc_pkg::DIV_D_W:0] trial;
	logic [bcc_pkg::DIV_D_W:0] diff;
	logic                      qbit;

	// restoring step: bring in the next dividend bit, subtract when it fits
	always_comb begin
		trial = {rem_q, dvd_q[bcc_pkg::DIV_N_W-1]};
		diff  = trial - {1'b0, dvs_q};
		qbit  = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == bcc_pkg::DIV_STEP_W'(bcc_pkg::DIV_N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			dvd_q <= {dvd_q[bcc_pkg::DIV_N_W-2:0], qbit};
			rem_q <= qbit ? diff[bcc_pkg::DIV_D_W-1:0] : trial[bcc_pkg::DIV_D_W-1:0];
		end else if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = dvd_q;
	assign rsp.remainder = rem_q;

endmodule

`default_nettype wire
